@@ sv/uvs_pkg.sv @@
`default_nettype none
package uvs_pkg;

	// build-time defaults and fixed formats
	localparam int ANGLE_BITS_DEF = 16;
	localparam int COUNT_MAX = 255;
	localparam int CNT_W = 8;
	localparam int MIN_SECTORS = 3;
	localparam int MIN_STACKS = 2;
	localparam int TEX_BITS = 16;
	localparam int SIN_LAT = 8;
	localparam int QUEUE_DEPTH = 4;

	// sine polynomial coefficients, unsigned Q30
	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598668;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026990;
	localparam logic [30:0] SIN_C9 = 31'd172272;

	// register indexes
	typedef enum logic [1:0] {
		REG_RADIUS  = 2'd0,
		REG_SECTORS = 2'd1,
		REG_STACKS  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] radius_q8_8;
		logic [7:0]  num_sectors;
		logic [7:0]  num_stacks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
	} req_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [16:0]        tex_s;
		logic [16:0]        tex_t;
		logic [16:0]        upper_index;
		logic [16:0]        lower_index;
		logic               upper_tri_valid;
		logic               lower_tri_valid;
	} rsp_t;

	// fields settled by the front and carried past the trig pipeline
	typedef struct packed {
		logic [16:0] tex_s;
		logic [16:0] tex_t;
		logic [16:0] upper_index;
		logic [16:0] lower_index;
		logic        upper_tri_valid;
		logic        lower_tri_valid;
	} side_t;

endpackage
`default_nettype wire

@@ sv/uvs_div.sv @@
`default_nettype none
// pipelined restoring divider: round((num << SHIFT) / den), one quotient bit per stage
module uvs_div #(
	parameter int SHIFT = 16,
	parameter int STAGES = 17
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [uvs_pkg::CNT_W-1:0] num,
	input wire logic [uvs_pkg::CNT_W-1:0] den,
	output logic [SHIFT:0] quo
);

	localparam int W = uvs_pkg::CNT_W;
	localparam int PAD = STAGES - SHIFT - 1;

	logic [SHIFT-1:0] low_bits;
	logic [W-1:0]   rem_q [STAGES];
	logic [SHIFT:0] quo_q [STAGES];

	// rounding term den/2 sits in the low dividend bits
	assign low_bits = SHIFT'(den >> 1);

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [W-1:0]   rem_in;
		logic [SHIFT:0] quo_in;
		logic [W:0]     trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		// delay stages, then the top step, then one dividend bit per stage
		if (k < PAD) begin : g_pad
			assign trial = {1'b0, rem_in};
			assign ge = 1'b0;
		end else if (k == PAD) begin : g_top
			assign trial = {1'b0, rem_in};
			assign ge = (trial >= {1'b0, den});
		end else begin : g_bit
			assign trial = {rem_in, low_bits[SHIFT-(k-PAD)]};
			assign ge = (trial >= {1'b0, den});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? W'(trial - {1'b0, den}) : W'(trial);
				quo_q[k] <= {quo_in[SHIFT-1:0], ge};
			end
		end
	end

	assign quo = quo_q[STAGES-1];

endmodule
`default_nettype wire

@@ sv/uvs_fifo.sv @@
`default_nettype none
// small show-ahead queue in flops
module uvs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty,
	output logic full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/uvs_front.sv @@
`default_nettype none
// front: clamps the grid point, forms indices and flags, divides out the phases and texture coordinates
module uvs_front #(
	parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire uvs_pkg::cfg_t cfg,
	input wire logic push,
	output logic full,
	input wire uvs_pkg::req_t req,
	input wire logic q_full,
	output logic q_push,
	output logic [ANGLE_BITS-1:0] q_theta,
	output logic [ANGLE_BITS-1:0] q_phi,
	output uvs_pkg::side_t q_side
);

	localparam int STAGES =
		(ANGLE_BITS > uvs_pkg::TEX_BITS ? ANGLE_BITS : uvs_pkg::TEX_BITS) + 1;

	logic en, take;
	logic [STAGES-1:0] vld_q;
	uvs_pkg::side_t side_q [STAGES];
	uvs_pkg::side_t side_new;
	logic [7:0] row_sat, col_sat;
	logic [8:0] secs1;
	logic [16:0] row_base, upper, lower;
	logic quad_ok;
	logic [ANGLE_BITS-1:0] theta_quo;
	logic [ANGLE_BITS:0] phi_quo;
	logic [uvs_pkg::TEX_BITS:0] tex_s_quo, tex_t_quo;

	// whole pipeline holds while its last request waits on a full queue
	assign en = !(vld_q[STAGES-1] && q_full);
	assign full = !en;
	assign take = push && en;

	// saturate row and column to the counts
	assign row_sat = (req.row > cfg.num_stacks) ? cfg.num_stacks : req.row;
	assign col_sat = (req.col > cfg.num_sectors) ? cfg.num_sectors : req.col;

	// vertex indices and triangle flags
	assign secs1 = {1'b0, cfg.num_sectors} + 9'd1;
	assign row_base = 17'(row_sat) * 17'(secs1);
	assign upper = row_base + {9'b0, col_sat};
	assign lower = upper + {8'b0, secs1};
	assign quad_ok = (row_sat < cfg.num_stacks) && (col_sat < cfg.num_sectors);

	always_comb begin
		side_new = '0;
		side_new.upper_index = upper;
		side_new.lower_index = lower;
		side_new.upper_tri_valid = quad_ok && (row_sat != 8'd0);
		side_new.lower_tri_valid = quad_ok && (row_sat != (cfg.num_stacks - 8'd1));
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], take};
		end
	end

	// side fields ride along with the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_new;
			for (int k = 1; k < STAGES; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// polar and azimuth phases, texture coordinates
	uvs_div #(.SHIFT(ANGLE_BITS - 1), .STAGES(STAGES)) u_div_theta (
		.clk(clk), .en(en), .num(row_sat), .den(cfg.num_stacks), .quo(theta_quo)
	);
	uvs_div #(.SHIFT(ANGLE_BITS), .STAGES(STAGES)) u_div_phi (
		.clk(clk), .en(en), .num(col_sat), .den(cfg.num_sectors), .quo(phi_quo)
	);
	uvs_div #(.SHIFT(uvs_pkg::TEX_BITS), .STAGES(STAGES)) u_div_tex_s (
		.clk(clk), .en(en), .num(col_sat), .den(cfg.num_sectors), .quo(tex_s_quo)
	);
	uvs_div #(.SHIFT(uvs_pkg::TEX_BITS), .STAGES(STAGES)) u_div_tex_t (
		.clk(clk), .en(en), .num(row_sat), .den(cfg.num_stacks), .quo(tex_t_quo)
	);

	assign q_push = en && vld_q[STAGES-1];
	assign q_theta = theta_quo;
	assign q_phi = phi_quo[ANGLE_BITS-1:0];

	always_comb begin
		q_side = side_q[STAGES-1];
		q_side.tex_s = tex_s_quo;
		q_side.tex_t = tex_t_quo;
	end

endmodule
`default_nettype wire

@@ sv/uvs_sin.sv @@
`default_nettype none
// pipelined sine of a phase in turns, signed Q30 result
module uvs_sin #(
	parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [ANGLE_BITS-1:0] phase,
	output logic signed [31:0] sin_val
);

	localparam logic [30:0] ONE = 31'd1 << 30;

	logic [29:0] xf;
	logic [30:0] x_in;
	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [30:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [30:0] p_s3, p_s4, p_s5, p_s6;
	logic [31:0] v_s7;
	logic [61:0] m2, m3, m4, m5, m6, m7;
	logic signed [31:0] sv;

	// quadrant fold: mirror in odd quadrants
	assign xf = 30'(phase[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
	assign x_in = phase[ANGLE_BITS-2] ? (ONE - {1'b0, xf}) : {1'b0, xf};

	// one product per stage, Horner on x squared
	assign m2 = x_s1 * x_s1;
	assign m3 = x2_s2 * uvs_pkg::SIN_C9;
	assign m4 = x2_s3 * p_s3;
	assign m5 = x2_s4 * p_s4;
	assign m6 = x2_s5 * p_s5;
	assign m7 = x_s6 * p_s6;
	assign sv = $signed(v_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_in;
			neg_s1 <= phase[ANGLE_BITS-1];

			x2_s2 <= m2[60:30];
			x_s2 <= x_s1;
			neg_s2 <= neg_s1;

			p_s3 <= uvs_pkg::SIN_C7 - m3[60:30];
			x2_s3 <= x2_s2;
			x_s3 <= x_s2;
			neg_s3 <= neg_s2;

			p_s4 <= uvs_pkg::SIN_C5 - m4[60:30];
			x2_s4 <= x2_s3;
			x_s4 <= x_s3;
			neg_s4 <= neg_s3;

			p_s5 <= uvs_pkg::SIN_C3 - m5[60:30];
			x2_s5 <= x2_s4;
			x_s5 <= x_s4;
			neg_s5 <= neg_s4;

			p_s6 <= uvs_pkg::SIN_C1 - m6[60:30];
			x_s6 <= x_s5;
			neg_s6 <= neg_s5;

			v_s7 <= m7[61:30];
			neg_s7 <= neg_s6;

			sin_val <= neg_s7 ? -sv : sv;
		end
	end

endmodule
`default_nettype wire

@@ sv/uvs_back.sv @@
`default_nettype none
// back: sines of both phases, then position and normal products with rounding
module uvs_back #(
	parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire uvs_pkg::cfg_t cfg,
	input wire logic q_empty,
	output logic q_pop,
	input wire logic [ANGLE_BITS-1:0] q_theta,
	input wire logic [ANGLE_BITS-1:0] q_phi,
	input wire uvs_pkg::side_t q_side,
	input wire logic o_full,
	output logic o_push,
	output uvs_pkg::rsp_t o_data
);

	localparam int LAT = uvs_pkg::SIN_LAT + 4;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic signed [15:0] POS_MIN = 16'sh8000;
	localparam logic signed [15:0] POS_MAX = 16'sh7FFF;
	localparam logic signed [15:0] NRM_MIN = -16'sd16384;
	localparam logic signed [15:0] NRM_MAX = 16'sd16384;

	// round half away from zero, arithmetic shift right
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
		logic signed [63:0] h;
		h = 64'sd1 <<< (sh - 1);
		if (v < 0) begin
			h = h - 64'sd1;
		end
		return (v + h) >>> sh;
	endfunction

	function automatic logic signed [15:0] rnd_sat(input logic signed [63:0] v, input int sh,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		logic signed [63:0] s;
		s = rnd(v, sh);
		if (s < lo) begin
			return lo;
		end
		if (s > hi) begin
			return hi;
		end
		return 16'(s);
	endfunction

	logic en;
	logic [LAT-1:0] vld_q;
	uvs_pkg::side_t side_q [LAT];
	logic signed [31:0] st, ct, sp, cp;

	logic signed [48:0] rst_s9, rct_s9;
	logic signed [63:0] nx_s9, ny_s9;
	logic signed [15:0] nz_s9;
	logic signed [31:0] cp_s9, sp_s9;

	logic signed [31:0] xy_s10, cp_s10, sp_s10;
	logic signed [15:0] posz_s10, nx_s10, ny_s10, nz_s10;

	logic signed [63:0] px_s11, py_s11;
	logic signed [15:0] posz_s11, nx_s11, ny_s11, nz_s11;

	logic signed [15:0] posx_s12, posy_s12, posz_s12, nx_s12, ny_s12, nz_s12;

	// hold everything while a finished request waits on the result queue
	assign en = !(vld_q[LAT-1] && o_full);
	assign q_pop = en && !q_empty;
	assign o_push = en && vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= q_side;
			for (int k = 1; k < LAT; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// sine and cosine of both phases
	uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_st (
		.clk(clk), .en(en), .phase(q_theta), .sin_val(st)
	);
	uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ct (
		.clk(clk), .en(en), .phase(q_theta + QUARTER), .sin_val(ct)
	);
	uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_sp (
		.clk(clk), .en(en), .phase(q_phi), .sin_val(sp)
	);
	uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_cp (
		.clk(clk), .en(en), .phase(q_phi + QUARTER), .sin_val(cp)
	);

	// products, rounding and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			rst_s9 <= $signed({1'b0, cfg.radius_q8_8}) * st;
			rct_s9 <= $signed({1'b0, cfg.radius_q8_8}) * ct;
			nx_s9 <= st * cp;
			ny_s9 <= st * sp;
			nz_s9 <= rnd_sat(ct, 16, NRM_MIN, NRM_MAX);
			cp_s9 <= cp;
			sp_s9 <= sp;

			xy_s10 <= 32'(rnd(rst_s9, 16));
			posz_s10 <= rnd_sat(rct_s9, 30, POS_MIN, POS_MAX);
			nx_s10 <= rnd_sat(nx_s9, 46, NRM_MIN, NRM_MAX);
			ny_s10 <= rnd_sat(ny_s9, 46, NRM_MIN, NRM_MAX);
			nz_s10 <= nz_s9;
			cp_s10 <= cp_s9;
			sp_s10 <= sp_s9;

			px_s11 <= xy_s10 * cp_s10;
			py_s11 <= xy_s10 * sp_s10;
			posz_s11 <= posz_s10;
			nx_s11 <= nx_s10;
			ny_s11 <= ny_s10;
			nz_s11 <= nz_s10;

			posx_s12 <= rnd_sat(px_s11, 44, POS_MIN, POS_MAX);
			posy_s12 <= rnd_sat(py_s11, 44, POS_MIN, POS_MAX);
			posz_s12 <= posz_s11;
			nx_s12 <= nx_s11;
			ny_s12 <= ny_s11;
			nz_s12 <= nz_s11;
		end
	end

	// assemble the result
	always_comb begin
		o_data.pos_x = posx_s12;
		o_data.pos_y = posy_s12;
		o_data.pos_z = posz_s12;
		o_data.norm_x = nx_s12;
		o_data.norm_y = ny_s12;
		o_data.norm_z = nz_s12;
		o_data.tex_s = side_q[LAT-1].tex_s;
		o_data.tex_t = side_q[LAT-1].tex_t;
		o_data.upper_index = side_q[LAT-1].upper_index;
		o_data.lower_index = side_q[LAT-1].lower_index;
		o_data.upper_tri_valid = side_q[LAT-1].upper_tri_valid;
		o_data.lower_tri_valid = side_q[LAT-1].lower_tri_valid;
	end

endmodule
`default_nettype wire

@@ sv/uv_sphere_vertex_generator.sv @@
// UV-sphere vertex generator: one grid point in, one vertex with quad indices out.
// Throughput: one request per cycle, sustained while the result queue keeps draining; else full holds requests off.
// Pipeline: the bit-per-stage phase dividers, then a queue, then the twelve-stage trig
// and product pipeline.
// Reset: radius 1.0, 36 sectors, 18 stacks; both queues empty; no clearing pass.
`default_nettype none
module uv_sphere_vertex_generator #(
	parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic push,
	output logic full,
	input wire uvs_pkg::req_t req,
	output logic empty,
	input wire logic pop,
	output uvs_pkg::rsp_t rsp
);

	localparam int SIDE_W = $bits(uvs_pkg::side_t);
	localparam int MID_W = 2 * ANGLE_BITS + SIDE_W;
	localparam int RSP_W = $bits(uvs_pkg::rsp_t);

	// count write with clamp to the legal range
	function automatic logic [7:0] clamp_count(input logic [7:0] v, input int lo);
		if (v < lo) begin
			return 8'(lo);
		end
		if (v > uvs_pkg::COUNT_MAX) begin
			return 8'(uvs_pkg::COUNT_MAX);
		end
		return v;
	endfunction

	uvs_pkg::cfg_t cfg_q;

	logic f_q_push, mid_full, mid_empty, b_q_pop;
	logic [ANGLE_BITS-1:0] f_theta, f_phi, b_theta, b_phi;
	uvs_pkg::side_t f_side, b_side;
	logic [MID_W-1:0] mid_rdata;

	logic o_push, o_full;
	uvs_pkg::rsp_t o_data;
	logic [RSP_W-1:0] out_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius_q8_8 <= 16'd256;
			cfg_q.num_sectors <= 8'd36;
			cfg_q.num_stacks <= 8'd18;
		end else if (cfg_we) begin
			case (cfg_index)
				uvs_pkg::REG_RADIUS: cfg_q.radius_q8_8 <= cfg_data;
				uvs_pkg::REG_SECTORS:
					cfg_q.num_sectors <= clamp_count(cfg_data[7:0], uvs_pkg::MIN_SECTORS);
				uvs_pkg::REG_STACKS:
					cfg_q.num_stacks <= clamp_count(cfg_data[7:0], uvs_pkg::MIN_STACKS);
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	uvs_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.full(full),
		.req(req),
		.q_full(mid_full),
		.q_push(f_q_push),
		.q_theta(f_theta),
		.q_phi(f_phi),
		.q_side(f_side)
	);

	// queue between front and back
	uvs_fifo #(.WIDTH(MID_W), .DEPTH(uvs_pkg::QUEUE_DEPTH)) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_q_push),
		.wdata({f_theta, f_phi, f_side}),
		.pop(b_q_pop),
		.rdata(mid_rdata),
		.empty(mid_empty),
		.full(mid_full)
	);

	assign {b_theta, b_phi, b_side} = mid_rdata;

	uvs_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(mid_empty),
		.q_pop(b_q_pop),
		.q_theta(b_theta),
		.q_phi(b_phi),
		.q_side(b_side),
		.o_full(o_full),
		.o_push(o_push),
		.o_data(o_data)
	);

	// result queue
	uvs_fifo #(.WIDTH(RSP_W), .DEPTH(uvs_pkg::QUEUE_DEPTH)) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(o_push),
		.wdata(o_data),
		.pop(pop),
		.rdata(out_rdata),
		.empty(empty),
		.full(o_full)
	);

	assign rsp = out_rdata;

endmodule
`default_nettype wire
